// ----- hdl/crc_checked_record_validator_assert.svh -----
// assertion macros for the calibration record validator checker
`ifndef CRC_CHECKED_RECORD_VALIDATOR_ASSERT_SVH
`define CRC_CHECKED_RECORD_VALIDATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CRCV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CRCV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/crcv_pkg.sv -----
// shared types, constants and the byte-wide crc-32 step for the record validator
package crcv_pkg;

  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned CRC_START    = 8;

  // configuration register indexes
  localparam logic [1:0] CFG_EXPECTED_MAGIC  = 2'd0;
  localparam logic [1:0] CFG_EXPECTED_SCHEMA = 2'd1;
  localparam logic [1:0] CFG_REQUIRED_MASK   = 2'd2;

  // header word slots, by byte offset bits [3:2]
  localparam logic [1:0] WORD_MAGIC  = 2'd0;
  localparam logic [1:0] WORD_CRC    = 2'd1;
  localparam logic [1:0] WORD_SCHEMA = 2'd2;
  localparam logic [1:0] WORD_MASK   = 2'd3;

  typedef struct packed {
    logic        record_ok;
    logic        magic_ok;
    logic        schema_ok;
    logic        crc_ok;
    logic        short_record;
    logic        mask_complete;
    logic [31:0] computed_crc;
    logic [31:0] stored_crc;
  } crcv_result_t;

  // one reflected crc-32 update over a single byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] x;
    x = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return (crc >> 8) ^ x;
  endfunction

endpackage

// ----- hdl/crcv_out_queue.sv -----
// two-entry result queue: output register plus skid register
module crcv_out_queue
  import crcv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  crcv_result_t push_data,
  output logic         full,
  output logic         out_valid,
  output crcv_result_t out_data,
  input  logic         out_stall
);

  logic         head_valid_r, head_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  crcv_result_t head_r, head_nxt;
  crcv_result_t skid_r, skid_nxt;
  logic         pop;

  assign pop       = head_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = head_valid_r;
  assign out_data  = head_r;

  // queue bookkeeping
  always_comb begin
    head_valid_nxt = head_valid_r;
    skid_valid_nxt = skid_valid_r;
    head_nxt       = head_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      // input is stalled, so only a pop can happen
      if (pop) begin
        head_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!head_valid_r || pop) begin
        head_nxt       = push_data;
        head_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      head_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ----- hdl/crc_checked_record_validator.sv -----
// top level: streaming crc-32 check of a stored calibration record
// The result for a record is registered into the output queue when its last byte is taken.
// Throughput: one byte per cycle unless stalled; the byte-wide crc-32 step feeds the compares.
// The input stalls only while two finished results wait in the output queue.
// Reset (rst_n low, synchronous) clears the config registers, the record state and the queue.
module crc_checked_record_validator
  import crcv_pkg::*;
#(
  parameter int unsigned MAX_RECORD_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_record_ok,
  output logic        out_magic_ok,
  output logic        out_schema_ok,
  output logic        out_crc_ok,
  output logic        out_short_record,
  output logic        out_mask_complete,
  output logic [31:0] out_computed_crc,
  output logic [31:0] out_stored_crc
);

  localparam int unsigned CNT_W = $clog2(MAX_RECORD_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_RECORD_BYTES);
  localparam logic [CNT_W-1:0] CNT_HEADER = CNT_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] CNT_CRC    = CNT_W'(CRC_START);

  logic [31:0]      exp_magic_r, exp_schema_r, req_mask_r;
  logic [CNT_W-1:0] count_r, count_nxt, count_upd;
  logic [31:0]      crc_r, crc_nxt, crc_upd;
  logic [31:0]      word_r   [4];
  logic [31:0]      word_nxt [4];
  logic [31:0]      word_upd [4];
  logic             accept;
  logic             queue_full;
  logic             push;
  crcv_result_t     res;
  crcv_result_t     q_out;
  logic             shortr;
  logic [31:0]      calc;

  assign accept   = in_valid && !in_stall;
  assign in_stall = queue_full;
  assign push     = accept && in_last_byte;

  // configuration registers, unknown index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_magic_r  <= '0;
      exp_schema_r <= '0;
      req_mask_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_EXPECTED_MAGIC:  exp_magic_r  <= cfg_wdata;
        CFG_EXPECTED_SCHEMA: exp_schema_r <= cfg_wdata;
        CFG_REQUIRED_MASK:   req_mask_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // record state after the incoming byte
  always_comb begin
    for (int w = 0; w < 4; w++) begin
      word_upd[w] = word_r[w];
    end
    if (count_r < CNT_HEADER) begin
      word_upd[count_r[3:2]][count_r[1:0]*8 +: 8] = in_data_byte;
    end
    crc_upd   = (count_r >= CNT_CRC) ? crc_byte(crc_r, in_data_byte) : crc_r;
    count_upd = (count_r != CNT_MAX) ? count_r + CNT_W'(1) : count_r;
  end

  // next state: hold, advance, or clear at end of record
  always_comb begin
    count_nxt = count_r;
    crc_nxt   = crc_r;
    for (int w = 0; w < 4; w++) begin
      word_nxt[w] = word_r[w];
    end
    if (accept) begin
      if (in_last_byte) begin
        count_nxt = '0;
        crc_nxt   = CRC_INIT;
        for (int w = 0; w < 4; w++) begin
          word_nxt[w] = '0;
        end
      end else begin
        count_nxt = count_upd;
        crc_nxt   = crc_upd;
        for (int w = 0; w < 4; w++) begin
          word_nxt[w] = word_upd[w];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      crc_r   <= CRC_INIT;
      for (int w = 0; w < 4; w++) begin
        word_r[w] <= '0;
      end
    end else begin
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      for (int w = 0; w < 4; w++) begin
        word_r[w] <= word_nxt[w];
      end
    end
  end

  // verdict for a record ending with this byte
  always_comb begin
    shortr            = count_upd < CNT_HEADER;
    calc              = ~crc_upd;
    res.magic_ok      = !shortr && (word_upd[WORD_MAGIC] == exp_magic_r);
    res.schema_ok     = !shortr && (word_upd[WORD_SCHEMA] == exp_schema_r);
    res.crc_ok        = !shortr && (calc == word_upd[WORD_CRC]);
    res.mask_complete = !shortr && ((word_upd[WORD_MASK] & req_mask_r) == req_mask_r);
    res.record_ok     = res.magic_ok && res.schema_ok && res.crc_ok;
    res.short_record  = shortr;
    res.computed_crc  = calc;
    res.stored_crc    = word_upd[WORD_CRC];
  end

  crcv_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .full      (queue_full),
    .out_valid (out_valid),
    .out_data  (q_out),
    .out_stall (out_stall)
  );

  assign out_record_ok     = q_out.record_ok;
  assign out_magic_ok      = q_out.magic_ok;
  assign out_schema_ok     = q_out.schema_ok;
  assign out_crc_ok        = q_out.crc_ok;
  assign out_short_record  = q_out.short_record;
  assign out_mask_complete = q_out.mask_complete;
  assign out_computed_crc  = q_out.computed_crc;
  assign out_stored_crc    = q_out.stored_crc;

endmodule

// ----- hdl/crcv_checker.sv -----
// port-level checker for the record validator, bound to the top level
`include "crc_checked_record_validator_assert.svh"

module crcv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_record_ok,
  input logic        out_magic_ok,
  input logic        out_schema_ok,
  input logic        out_crc_ok,
  input logic        out_short_record,
  input logic        out_mask_complete,
  input logic [31:0] out_computed_crc,
  input logic [31:0] out_stored_crc
);

  // a stalled transaction stays offered
  `CRCV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // a stalled transaction keeps its payload
  `CRCV_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_computed_crc) && $stable(out_stored_crc) && $stable(out_record_ok), "result changed while stalled")

  // overall verdict is the three matches together
  `CRCV_ASSERT_NOW(a_record_ok, out_valid, out_record_ok == (out_magic_ok && out_schema_ok && out_crc_ok), "record_ok disagrees with match flags")

  // a short record passes no check
  `CRCV_ASSERT_NOW(a_short, out_valid && out_short_record, !out_magic_ok && !out_schema_ok && !out_crc_ok && !out_mask_complete, "short record reported a match")

  // crc match means the two words agree
  `CRCV_ASSERT_NOW(a_crc_eq, out_valid && out_crc_ok, out_computed_crc == out_stored_crc, "crc_ok with differing crc words")

endmodule

bind crc_checked_record_validator crcv_checker u_crcv_checker (.*);
